// ===== rtl/alsc_pkg.sv =====
// Shared constants and controller/datapath handshake types for the LRU stamp cache.
`default_nettype none

package alsc_pkg;

  // Field widths fixed by the item format.
  localparam int unsigned CmdW   = 2;
  localparam int unsigned KeyW   = 32;
  localparam int unsigned ValW   = 32;
  localparam int unsigned SlotW  = 4;
  localparam int unsigned StampW = 64;

  // Default number of cache entries.
  localparam int unsigned DefEntries = 16;

  // Command codes.
  localparam logic [CmdW-1:0] CmdFind  = 2'd0;
  localparam logic [CmdW-1:0] CmdAdd   = 2'd1;
  localparam logic [CmdW-1:0] CmdClear = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the input beat and restart the scan
    logic scan_step;  // read the entry at the scan pointer
    logic commit;     // apply the state update of the command
    logic resp_load;  // move the result into the output register
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;  // scan pointer sits on the last entry
    logic out_free;   // output register can take a result this cycle
  } stat_t;

endpackage

`default_nettype wire

// ===== rtl/alsc_in_if.sv =====
// Request channel: command, key and value with a valid/ready handshake.
`default_nettype none

interface alsc_in_if import alsc_pkg::*; ();

  logic            valid;
  logic            ready;
  logic [CmdW-1:0] cmd;
  logic [KeyW-1:0] key;
  logic [ValW-1:0] value;

  modport source (output valid, output cmd, output key, output value, input ready);
  modport sink   (input valid, input cmd, input key, input value, output ready);

endinterface

`default_nettype wire

// ===== rtl/alsc_out_if.sv =====
// Response channel: hit flag, value and slot with a valid/ready handshake.
`default_nettype none

interface alsc_out_if import alsc_pkg::*; ();

  logic             valid;
  logic             ready;
  logic             hit;
  logic [ValW-1:0]  value_out;
  logic [SlotW-1:0] slot;

  modport source (output valid, output hit, output value_out, output slot, input ready);
  modport sink   (input valid, input hit, input value_out, input slot, output ready);

endinterface

`default_nettype wire

// ===== rtl/alsc_ctrl.sv =====
// Controller state machine: sequences accept, entry scan, commit and response.
`default_nettype none

module alsc_ctrl import alsc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT,
    ST_RESP
  } state_e;

  state_e state_q, state_d;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat_i.scan_last) state_d = ST_DRAIN;
      end
      ST_DRAIN:  state_d = ST_COMMIT;
      ST_COMMIT: state_d = ST_RESP;
      ST_RESP: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Command decode from the current state.
  assign in_ready_o       = (state_q == ST_IDLE);
  assign ctrl_o.load      = (state_q == ST_IDLE) && in_valid_i;
  assign ctrl_o.scan_step = (state_q == ST_SCAN);
  assign ctrl_o.commit    = (state_q == ST_COMMIT);
  assign ctrl_o.resp_load = (state_q == ST_RESP) && stat_i.out_free;

endmodule

`default_nettype wire

// ===== rtl/alsc_dp.sv =====
// Datapath: entry stores, valid bits, scan compare, stamp counter and output register.
`default_nettype none

module alsc_dp import alsc_pkg::*; #(
  parameter int unsigned Entries = DefEntries
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CmdW-1:0]  cmd_i,
  input  logic [KeyW-1:0]  key_i,
  input  logic [ValW-1:0]  value_i,
  input  ctrl_t            ctrl_i,
  output stat_t            stat_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             hit_o,
  output logic [ValW-1:0]  value_out_o,
  output logic [SlotW-1:0] slot_o
);

  localparam int unsigned IdxW = $clog2(Entries);
  localparam int unsigned CntW = IdxW + 1;

  // Entry stores; an entry whose valid bit is low reads as zero.
  logic [KeyW-1:0]   key_mem   [Entries];
  logic [ValW-1:0]   val_mem   [Entries];
  logic [StampW-1:0] stamp_mem [Entries];
  logic [Entries-1:0] key_vld_q, val_vld_q, stamp_vld_q;

  // Captured request.
  logic [CmdW-1:0] cmd_q;
  logic [KeyW-1:0] key_q;
  logic [ValW-1:0] value_q;

  // Scan pointer and read stage.
  logic [CntW-1:0]   cnt_q;
  logic [IdxW-1:0]   rd_addr;
  logic              rd_en_q;
  logic [IdxW-1:0]   rd_idx_q;
  logic [KeyW-1:0]   rd_key_q;
  logic [ValW-1:0]   rd_val_q;
  logic [StampW-1:0] rd_stamp_q;
  logic              rd_kvld_q, rd_vvld_q, rd_svld_q;
  logic [KeyW-1:0]   key_eff;
  logic [ValW-1:0]   val_eff;
  logic [StampW-1:0] stamp_eff;

  // Scan results.
  logic              found_q;
  logic [IdxW-1:0]   sel_idx_q;
  logic [ValW-1:0]   hit_val_q;
  logic [StampW-1:0] least_q;

  // Global stamp counter.
  logic [StampW-1:0] ctr_q;
  logic [StampW-1:0] ctr_inc;

  // Output register.
  logic             out_valid_q;
  logic             hit_q;
  logic [ValW-1:0]  value_out_q;
  logic [SlotW-1:0] slot_q;

  // Result of the current command.
  logic             res_hit;
  logic             res_slot_en;
  logic [IdxW+3:0]  sel_ext;

  assign rd_addr   = cnt_q[IdxW-1:0];
  assign key_eff   = rd_kvld_q ? rd_key_q : '0;
  assign val_eff   = rd_vvld_q ? rd_val_q : '0;
  assign stamp_eff = rd_svld_q ? rd_stamp_q : '0;
  assign ctr_inc   = ctr_q + StampW'(1);

  assign stat_o.scan_last = (cnt_q == CntW'(Entries - 1));
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  // Request capture; payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q   <= cmd_i;
      key_q   <= key_i;
      value_q <= value_i;
    end
  end

  // Scan pointer and read-stage control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      rd_en_q <= 1'b0;
    end else begin
      rd_en_q <= ctrl_i.scan_step;
      if (ctrl_i.load) begin
        cnt_q <= '0;
      end else if (ctrl_i.scan_step) begin
        cnt_q <= cnt_q + CntW'(1);
      end
    end
  end

  // Registered reads of the entry under the scan pointer.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.scan_step) begin
      rd_idx_q   <= rd_addr;
      rd_key_q   <= key_mem[rd_addr];
      rd_val_q   <= val_mem[rd_addr];
      rd_stamp_q <= stamp_mem[rd_addr];
      rd_kvld_q  <= key_vld_q[rd_addr];
      rd_vvld_q  <= val_vld_q[rd_addr];
      rd_svld_q  <= stamp_vld_q[rd_addr];
    end
  end

  // Find keeps the first match; add keeps the first smallest stamp.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (ctrl_i.load) begin
      found_q <= 1'b0;
    end else if (rd_en_q && (cmd_q == CmdFind) && !found_q && (key_eff == key_q)) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_q) begin
      if ((cmd_q == CmdFind) && !found_q && (key_eff == key_q)) begin
        sel_idx_q <= rd_idx_q;
        hit_val_q <= val_eff;
      end else if ((cmd_q == CmdAdd) &&
                   ((rd_idx_q == '0) || (stamp_eff < least_q))) begin
        sel_idx_q <= rd_idx_q;
        least_q   <= stamp_eff;
      end
    end
  end

  // Store writes at commit.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.commit) begin
      if (cmd_q == CmdAdd) begin
        key_mem[sel_idx_q]   <= key_q;
        val_mem[sel_idx_q]   <= value_q;
        stamp_mem[sel_idx_q] <= ctr_inc;
      end else if ((cmd_q == CmdFind) && found_q) begin
        stamp_mem[sel_idx_q] <= ctr_inc;
      end
    end
  end

  // Valid bits and stamp counter at commit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_vld_q   <= '0;
      val_vld_q   <= '0;
      stamp_vld_q <= '0;
      ctr_q       <= '0;
    end else if (ctrl_i.commit) begin
      case (cmd_q)
        CmdFind: begin
          if (found_q) begin
            stamp_vld_q[sel_idx_q] <= 1'b1;
            ctr_q                  <= ctr_inc;
          end
        end
        CmdAdd: begin
          key_vld_q[sel_idx_q]   <= 1'b1;
          val_vld_q[sel_idx_q]   <= 1'b1;
          stamp_vld_q[sel_idx_q] <= 1'b1;
          ctr_q                  <= ctr_inc;
        end
        CmdClear: begin
          key_vld_q   <= '0;
          stamp_vld_q <= '0;
          ctr_q       <= '0;
        end
        default: begin
          ctr_q <= ctr_q;
        end
      endcase
    end
  end

  // Result fields of the current command.
  assign res_hit     = (cmd_q == CmdFind) && found_q;
  assign res_slot_en = res_hit || (cmd_q == CmdAdd);
  assign sel_ext     = {4'b0000, sel_idx_q};

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.resp_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.resp_load) begin
      hit_q       <= res_hit;
      value_out_q <= res_hit ? hit_val_q : '0;
      slot_q      <= res_slot_en ? sel_ext[SlotW-1:0] : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;
  assign value_out_o = value_out_q;
  assign slot_o      = slot_q;

endmodule

`default_nettype wire

// ===== rtl/assoc_lru_stamp_cache_core.sv =====
// Top level of the fully associative key-to-value cache with stamp-based LRU replacement.
//
// Usage: each request beat on in_i carries a command (find, add or clear), a key
// and a value; each request produces exactly one response beat on out_o with the
// hit flag, the matched value and the entry slot. Both channels use valid/ready.
// Timing: after a request is taken, the controller scans all ENTRIES entries one
// per cycle through the registered read port of the entry stores, then commits
// the update and loads the response into the output register. One request is in
// flight at a time: a new request is taken only once the previous response has
// been loaded.
// Back pressure: the response sits in an output register; a new request can be
// accepted while that response waits, but the next response is held until the
// receiver takes the previous one.
// Reset: all entries read as empty with zero value and zero stamp, and the stamp
// counter is zero. Per-entry valid bits give this at once, so the block accepts
// requests straight out of reset.
`default_nettype none

module assoc_lru_stamp_cache_core import alsc_pkg::*; #(
  parameter int unsigned ENTRIES = DefEntries
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  alsc_in_if.sink           in_i,
  alsc_out_if.source        out_o
);

  ctrl_t ctrl;
  stat_t stat;
  logic  in_ready;

  alsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  alsc_dp #(
    .Entries (ENTRIES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (in_i.cmd),
    .key_i       (in_i.key),
    .value_i     (in_i.value),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .hit_o       (out_o.hit),
    .value_out_o (out_o.value_out),
    .slot_o      (out_o.slot)
  );

  assign in_i.ready = in_ready;

`ifndef SYNTHESIS
  // A response without a hit never carries a value.
  a_miss_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.hit) |-> (out_o.value_out == '0))
    else $error("response without hit carries a nonzero value");

  // No scan or commit runs while a new request can be taken.
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready |-> (!ctrl.scan_step && !ctrl.commit))
    else $error("scan or commit active while request port is ready");

  // The state update of a request is applied exactly once.
  a_single_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.commit |=> !ctrl.commit)
    else $error("commit asserted on consecutive cycles");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_assoc_lru_stamp_cache_core.sv =====
// Self-checking testbench for the fully associative LRU stamp cache core.
`default_nettype none

module tb_assoc_lru_stamp_cache_core;
  import alsc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Entries    = DefEntries;
  localparam int unsigned KeyPoolSz  = 20;
  localparam int unsigned PhaseItems = 133;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned MaxReports = 10;
  localparam int unsigned SettleCyc  = Entries + 8;

  // The one command code that the package leaves unnamed.
  localparam logic [CmdW-1:0] CmdUnused = 2'd3;

  typedef struct packed {
    logic             hit;
    logic [ValW-1:0]  value;
    logic [SlotW-1:0] slot;
  } rsp_t;

  typedef struct packed {
    logic [CmdW-1:0] cmd;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
    logic            typed;  // use the written-out response instead of the predictor
    rsp_t            want;
  } req_row_t;

  localparam rsp_t NoRsp  = '{1'b0, 32'h0, 4'd0};
  localparam rsp_t AnyRsp = '{1'b0, 32'h0, 4'd0};

  // Directed requests: corner keys and values, every command, duplicates and clears.
  localparam int unsigned NumDirected = 20;
  localparam req_row_t DirectedRows [NumDirected] = '{
    '{CmdFind,   32'h1234_5678, 32'h0000_0000, 1'b1, NoRsp},
    '{CmdUnused, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, NoRsp},
    '{CmdFind,   32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b1, 32'h0, 4'd0}},
    '{CmdAdd,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, AnyRsp},
    '{CmdFind,   32'hFFFF_FFFF, 32'h0000_0000, 1'b0, AnyRsp},
    '{CmdAdd,    32'h0000_0000, 32'hA5A5_A5A5, 1'b0, AnyRsp},
    '{CmdFind,   32'h0000_0000, 32'hFFFF_FFFF, 1'b0, AnyRsp},
    '{CmdAdd,    32'h8000_0000, 32'h0000_0001, 1'b0, AnyRsp},
    '{CmdAdd,    32'h7FFF_FFFF, 32'h8000_0000, 1'b0, AnyRsp},
    '{CmdAdd,    32'h5555_5555, 32'hAAAA_AAAA, 1'b0, AnyRsp},
    '{CmdAdd,    32'hAAAA_AAAA, 32'h5555_5555, 1'b0, AnyRsp},
    '{CmdAdd,    32'hFFFF_FFFF, 32'h1111_1111, 1'b0, AnyRsp},
    '{CmdFind,   32'hFFFF_FFFF, 32'h0000_0000, 1'b0, AnyRsp},
    '{CmdFind,   32'hAAAA_AAAA, 32'h0000_0000, 1'b0, AnyRsp},
    '{CmdClear,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, NoRsp},
    '{CmdFind,   32'hFFFF_FFFF, 32'h0000_0000, 1'b1, NoRsp},
    '{CmdAdd,    32'h0000_0001, 32'h0000_0000, 1'b1, NoRsp},
    '{CmdFind,   32'h0000_0000, 32'h0000_0000, 1'b0, AnyRsp},
    '{CmdUnused, 32'h0000_0000, 32'h0000_0000, 1'b1, NoRsp},
    '{CmdFind,   32'h0000_0001, 32'h0000_0000, 1'b0, AnyRsp}
  };

  logic clk;
  logic rst_n;

  alsc_in_if  req_if ();
  alsc_out_if rsp_if ();

  assoc_lru_stamp_cache_core #(
    .ENTRIES(Entries)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (req_if),
    .out_o (rsp_if)
  );

  // Shadow copy of the cache contents.
  logic [KeyW-1:0]   shadow_keys   [Entries];
  logic [ValW-1:0]   shadow_vals   [Entries];
  logic [StampW-1:0] shadow_stamps [Entries];
  logic [StampW-1:0] shadow_clock;

  rsp_t            pending_rsps [$];
  logic [KeyW-1:0] key_pool     [KeyPoolSz];
  int unsigned     mismatches;
  int unsigned     send_idle_pct;
  int unsigned     recv_stall_pct;
  int unsigned     hold_requests;
  int unsigned     hold_served;
  int unsigned     hold_left;

  // Empties the shadow cache; values survive a clear.
  function automatic void shadow_clear();
    shadow_clock = '0;
    for (int i = 0; i < Entries; i++) begin
      shadow_keys[i]   = '0;
      shadow_stamps[i] = '0;
    end
  endfunction

  // Applies one request to the shadow cache and returns the response it gives.
  function automatic rsp_t cache_access(logic [CmdW-1:0] cmd, logic [KeyW-1:0] key,
                                        logic [ValW-1:0] value);
    rsp_t              rsp;
    int                victim;
    logic [StampW-1:0] oldest;
    rsp    = '0;
    victim = 0;
    case (cmd)
      CmdFind: begin
        for (int i = 0; i < Entries; i++) begin
          if (!rsp.hit && shadow_keys[i] == key) begin
            shadow_clock     = shadow_clock + 1'b1;
            shadow_stamps[i] = shadow_clock;
            rsp.hit          = 1'b1;
            rsp.value        = shadow_vals[i];
            rsp.slot         = i[SlotW-1:0];
          end
        end
      end
      CmdAdd: begin
        // Lowest index among the oldest stamps is replaced.
        oldest = shadow_stamps[0];
        for (int i = 1; i < Entries; i++) begin
          if (shadow_stamps[i] < oldest) begin
            oldest = shadow_stamps[i];
            victim = i;
          end
        end
        shadow_clock          = shadow_clock + 1'b1;
        shadow_stamps[victim] = shadow_clock;
        shadow_keys[victim]   = key;
        shadow_vals[victim]   = value;
        rsp.slot              = victim[SlotW-1:0];
      end
      CmdClear: begin
        shadow_clear();
      end
      default: begin
      end
    endcase
    return rsp;
  endfunction

  // Offers one request beat and records its response once the beat is taken.
  task automatic send_req(input req_row_t row);
    rsp_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.cmd   <= row.cmd;
    req_if.key   <= row.key;
    req_if.value <= row.value;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    pred = cache_access(row.cmd, row.key, row.value);
    if (row.typed) pred = row.want;
    pending_rsps = {pending_rsps, pred};
  endtask

  // Builds a random request, mostly finds and adds on a small key set.
  function automatic req_row_t random_req();
    req_row_t    row;
    int unsigned pick;
    row  = '0;
    pick = $urandom_range(99);
    if (pick < 48)      row.cmd = CmdFind;
    else if (pick < 93) row.cmd = CmdAdd;
    else if (pick < 96) row.cmd = CmdClear;
    else                row.cmd = CmdUnused;
    pick = $urandom_range(99);
    if (pick < 80)      row.key = key_pool[$urandom_range(KeyPoolSz - 1)];
    else if (pick < 95) row.key = $urandom;
    else                row.key = '0;
    row.value = $urandom;
    return row;
  endfunction

  // Holds the sender back until every response is in, then lets the core settle.
  task automatic drain();
    req_if.valid <= 1'b0;
    while (pending_rsps.size() != 0) @(posedge clk);
    repeat (SettleCyc) @(posedge clk);
  endtask

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit, several times the slowest legal run.
  initial begin
    #5ms;
    $display("tb_assoc_lru_stamp_cache_core: FAIL");
    $finish;
  end

  // Response side: random stalls plus long hold-offs on request.
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_requests) begin
        hold_left   = HoldCycles;
        hold_served = hold_served + 1;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Response checker: each accepted beat against the oldest pending response.
  initial begin
    rsp_t want;
    forever begin
      @(posedge clk);
      if (rst_n && rsp_if.valid && rsp_if.ready) begin
        if (pending_rsps.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= MaxReports)
            $display("%0t: response beat with none pending: hit=%0b value=%h slot=%0d",
                     $realtime, rsp_if.hit, rsp_if.value_out, rsp_if.slot);
        end else begin
          want = pending_rsps.pop_front();
          if (rsp_if.hit !== want.hit || rsp_if.value_out !== want.value ||
              rsp_if.slot !== want.slot) begin
            mismatches = mismatches + 1;
            if (mismatches <= MaxReports)
              $display({"%0t: mismatch: want hit=%0b value=%h slot=%0d, ",
                        "got hit=%0b value=%h slot=%0d"},
                       $realtime, want.hit, want.value, want.slot,
                       rsp_if.hit, rsp_if.value_out, rsp_if.slot);
          end
        end
      end
    end
  end

  // Main sequence: reset, directed rows, then four phases of random traffic.
  initial begin
    mismatches     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_requests  = 0;
    hold_served    = 0;
    hold_left      = 0;
    rst_n          = 1'b0;
    req_if.valid   = 1'b0;
    req_if.cmd     = CmdFind;
    req_if.key     = '0;
    req_if.value   = '0;
    for (int i = 0; i < Entries; i++) shadow_vals[i] = '0;
    shadow_clear();
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < KeyPoolSz; i++) key_pool[i] = $urandom;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DirectedRows[i]) send_req(DirectedRows[i]);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      // Block the response side for a long stretch so the core backs up its input.
      if (phase == 0) hold_requests = hold_requests + 1;
      for (int n = 0; n < PhaseItems; n++) send_req(random_req());
      drain();
    end

    if (mismatches == 0 && pending_rsps.size() == 0) begin
      $display("tb_assoc_lru_stamp_cache_core: PASS");
    end else begin
      $display("tb_assoc_lru_stamp_cache_core: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/alsc_pkg.sv
rtl/alsc_in_if.sv
rtl/alsc_out_if.sv
rtl/alsc_ctrl.sv
rtl/alsc_dp.sv
rtl/assoc_lru_stamp_cache_core.sv
sim/tb_assoc_lru_stamp_cache_core.sv
